// ===== design/dlf_pkg.sv =====
// Package for the dense layer: formats, codes, state types and activation tables.
package dlf_pkg;

    localparam int DW          = 16;
    localparam int VW          = 28;
    localparam int MW          = 51;
    localparam int TDATA_IN_W  = 32;
    localparam int TDATA_OUT_W = 40;
    localparam int PADDR_W     = 4;

    localparam logic [5:0] DIV1_LAST = 6'd24;
    localparam logic [5:0] DIV2_LAST = 6'd40;

    typedef enum logic [1:0] {
        CMD_WEIGHT = 2'd0,
        CMD_INPUT  = 2'd1,
        CMD_RERUN  = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        MODE_SIGMOID  = 3'd0,
        MODE_RELU     = 3'd1,
        MODE_TANH     = 3'd2,
        MODE_IDENTITY = 3'd3,
        MODE_THRESH   = 3'd4,
        MODE_LEAKY    = 3'd5,
        MODE_SOFTPLUS = 3'd6,
        MODE_ATAN     = 3'd7
    } act_mode_t;

    typedef enum logic [1:0] {
        REG_MODE    = 2'd0,
        REG_INPUTS  = 2'd1,
        REG_NEURONS = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_START,
        ST_ACT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [3:0] {
        ACT_IDLE,
        ACT_LOOK,
        ACT_MUL,
        ACT_FIN,
        ACT_SQ,
        ACT_CUBE,
        ACT_DIV1,
        ACT_DIV2,
        ACT_ATAN,
        ACT_DONE
    } act_state_t;

    typedef struct packed {
        logic rd_en;
        logic rd_bias;
        logic clr;
    } mac_ctrl_t;

    typedef struct packed {
        logic      start;
        act_mode_t mode;
    } act_req_t;

    function automatic logic signed [17:0] tab_val(input act_mode_t mode, input logic [4:0] idx);
        logic signed [17:0] v;
        v = '0;
        if (mode == MODE_SOFTPLUS)
        begin
            case (idx)
                5'd0:  v = 18'sd45426;
                5'd1:  v = 18'sd31069;
                5'd2:  v = 18'sd20530;
                5'd3:  v = 18'sd13200;
                5'd4:  v = 18'sd8318;
                5'd5:  v = 18'sd5170;
                5'd6:  v = 18'sd3184;
                5'd7:  v = 18'sd1950;
                5'd8:  v = 18'sd1189;
                5'd9:  v = 18'sd724;
                5'd10: v = 18'sd440;
                5'd11: v = 18'sd267;
                5'd12: v = 18'sd162;
                5'd13: v = 18'sd98;
                5'd14: v = 18'sd60;
                5'd15: v = 18'sd36;
                default: v = 18'sd22;
            endcase
        end
        else if (mode == MODE_ATAN)
        begin
            case (idx)
                5'd0:  v = 18'sd0;
                5'd1:  v = 18'sd30386;
                5'd2:  v = 18'sd51472;
                5'd3:  v = 18'sd64408;
                5'd4:  v = 18'sd72558;
                5'd5:  v = 18'sd78007;
                5'd6:  v = 18'sd81857;
                5'd7:  v = 18'sd84705;
                5'd8:  v = 18'sd86889;
                5'd9:  v = 18'sd88613;
                5'd10: v = 18'sd90007;
                5'd11: v = 18'sd91157;
                5'd12: v = 18'sd92121;
                5'd13: v = 18'sd92940;
                5'd14: v = 18'sd93644;
                5'd15: v = 18'sd94257;
                default: v = 18'sd94794;
            endcase
        end
        else
        begin
            case (idx)
                5'd0:  v = 18'sd32768;
                5'd1:  v = 18'sd40793;
                5'd2:  v = 18'sd47911;
                5'd3:  v = 18'sd53581;
                5'd4:  v = 18'sd57724;
                5'd5:  v = 18'sd60565;
                5'd6:  v = 18'sd62428;
                5'd7:  v = 18'sd63615;
                5'd8:  v = 18'sd64357;
                5'd9:  v = 18'sd64816;
                5'd10: v = 18'sd65097;
                5'd11: v = 18'sd65269;
                5'd12: v = 18'sd65374;
                5'd13: v = 18'sd65437;
                5'd14: v = 18'sd65476;
                5'd15: v = 18'sd65500;
                default: v = 18'sd65513;
            endcase
        end
        return v;
    endfunction

    // Q.16 to Q7.8, round half up
    function automatic logic signed [VW-1:0] rnd_q16(input logic signed [VW-1:0] v);
        return (v + VW'(128)) >>> 8;
    endfunction

    function automatic logic signed [DW-1:0] sat_dw(input logic signed [VW-1:0] v);
        logic signed [DW-1:0] r;
        if (v > VW'(32767))
            r = 16'sh7fff;
        else if (v < -VW'(32768))
            r = 16'sh8000;
        else
            r = v[DW-1:0];
        return r;
    endfunction

endpackage

// ===== design/dlf_mac.sv =====
// Weight and input stores with the shared multiply-accumulate unit.
module dlf_mac
    import dlf_pkg::*;
#(
    parameter int WDEPTH = 1040,
    parameter int WAW    = 11,
    parameter int XDEPTH = 64,
    parameter int XW     = 6,
    parameter int ACC_W  = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    w_we,
    input  logic [WAW-1:0]          w_waddr,
    input  logic signed [DW-1:0]    w_wdata,
    input  logic                    x_we,
    input  logic [XW-1:0]           x_waddr,
    input  logic signed [DW-1:0]    x_wdata,
    input  mac_ctrl_t               ctrl,
    input  logic [WAW-1:0]          w_raddr,
    input  logic [XW-1:0]           x_raddr,
    output logic signed [ACC_W-1:0] acc
);

    logic signed [DW-1:0]    w_mem [WDEPTH];
    logic signed [DW-1:0]    x_mem [XDEPTH];
    logic signed [DW-1:0]    w_rd_reg;
    logic signed [DW-1:0]    x_rd_reg;
    logic                    dv_reg;
    logic                    dbias_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [2*DW-1:0]  prod;

    always_ff @(posedge clk)
    begin
        if (w_we)
            w_mem[w_waddr] <= w_wdata;
        w_rd_reg <= w_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr] <= x_wdata;
        x_rd_reg <= x_mem[x_raddr];
    end

    assign prod = w_rd_reg * x_rd_reg;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clr)
            acc_next = '0;
        else if (dv_reg)
        begin
            if (dbias_reg)
                acc_next = acc_reg + (ACC_W'(w_rd_reg) <<< 8);
            else
                acc_next = acc_reg + ACC_W'(prod);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_reg    <= 1'b0;
            dbias_reg <= 1'b0;
            acc_reg   <= '0;
        end
        else
        begin
            dv_reg    <= ctrl.rd_en;
            dbias_reg <= ctrl.rd_bias;
            acc_reg   <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

// ===== design/dlf_act.sv =====
// Activation unit: table interpolation, shared multiplier and serial divider.
module dlf_act
    import dlf_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  act_req_t             req,
    input  logic signed [DW-1:0] z,
    output logic                 done,
    output logic signed [DW-1:0] result
);

    act_state_t           state_reg, state_next;
    logic signed [DW-1:0] z_reg;
    act_mode_t            mode_reg;
    logic                 neg_reg;
    logic [16:0]          a_reg;
    logic signed [17:0]   t0_reg;
    logic signed [17:0]   d_reg;
    logic [6:0]           f_reg;
    logic signed [MW-1:0] prod_reg;
    logic [MW-1:0]        rem_reg;
    logic [MW-1:0]        den_reg;
    logic [24:0]          quo_reg;
    logic [14:0]          q1_reg;
    logic [5:0]           cnt_reg;
    logic signed [DW-1:0] result_reg;

    logic signed [17:0]   x;
    logic [16:0]          a;
    logic                 big;
    logic signed [17:0]   t0_l;
    logic signed [17:0]   d_l;
    logic signed [32:0]   mul_a;
    logic signed [17:0]   mul_b;
    logic signed [MW-1:0] prod;
    logic [MW-1:0]        r2;
    logic                 ge;
    logic [MW-1:0]        rem_n;
    logic [24:0]          quo_n;
    logic signed [VW-1:0] t;
    logic signed [VW-1:0] sig;
    logic signed [VW-1:0] v;
    logic signed [VW-1:0] t_at;

    // lookup operands
    always_comb
    begin
        if (mode_reg == MODE_TANH)
            x = {z_reg[DW-1], z_reg, 1'b0};
        else
            x = {{2{z_reg[DW-1]}}, z_reg};
        a    = x[17] ? 17'(-x) : 17'(x);
        big  = (a[16:11] != '0);
        t0_l = tab_val(mode_reg, big ? 5'd16 : {1'b0, a[10:7]});
        d_l  = big ? '0 : (tab_val(mode_reg, {1'b0, a[10:7]} + 5'd1) - t0_l);
    end

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ACT_MUL:
            begin
                if (mode_reg == MODE_LEAKY)
                begin
                    mul_a = 33'(z_reg);
                    mul_b = 18'sd655;
                end
                else
                begin
                    mul_a = 33'(d_reg);
                    mul_b = $signed({11'b0, f_reg});
                end
            end
            ACT_SQ:
            begin
                mul_a = $signed({16'b0, a_reg});
                mul_b = $signed({1'b0, a_reg});
            end
            ACT_CUBE:
            begin
                mul_a = prod_reg[32:0];
                mul_b = $signed({1'b0, a_reg});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = mul_a * mul_b;
    end

    // restoring divide of a power of two, one bit per cycle
    always_comb
    begin
        r2    = {rem_reg[MW-2:0], (cnt_reg == 6'd0)};
        ge    = (r2 >= den_reg);
        rem_n = ge ? (r2 - den_reg) : r2;
        quo_n = {quo_reg[23:0], ge};
    end

    always_comb
    begin
        t    = VW'(t0_reg) + VW'(prod_reg >>> 7);
        sig  = neg_reg ? (VW'(65536) - t) : t;
        t_at = VW'(102944) - $signed({13'b0, q1_reg}) + $signed({3'b0, quo_reg});
        v    = VW'(z_reg);
        case (mode_reg)
            MODE_SIGMOID:  v = rnd_q16(sig);
            MODE_RELU:     v = z_reg[DW-1] ? '0 : VW'(z_reg);
            MODE_TANH:     v = rnd_q16((sig <<< 1) - VW'(65536));
            MODE_IDENTITY: v = VW'(z_reg);
            MODE_THRESH:   v = z_reg[DW-1] ? '0 : VW'(256);
            MODE_LEAKY:    v = z_reg[DW-1] ? VW'((prod_reg + MW'(32768)) >>> 16) : VW'(z_reg);
            MODE_SOFTPLUS: v = rnd_q16(((z_reg > 0) ? (VW'(z_reg) <<< 8) : '0) + t);
            default:       v = rnd_q16(neg_reg ? -t : t);
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ACT_IDLE: if (req.start) state_next = ACT_LOOK;
            ACT_LOOK: state_next = (mode_reg == MODE_ATAN && big) ? ACT_SQ : ACT_MUL;
            ACT_MUL:  state_next = ACT_FIN;
            ACT_FIN:  state_next = ACT_DONE;
            ACT_SQ:   state_next = ACT_CUBE;
            ACT_CUBE: state_next = ACT_DIV1;
            ACT_DIV1: if (cnt_reg == DIV1_LAST) state_next = ACT_DIV2;
            ACT_DIV2: if (cnt_reg == DIV2_LAST) state_next = ACT_ATAN;
            ACT_ATAN: state_next = ACT_DONE;
            ACT_DONE: state_next = ACT_IDLE;
            default:  state_next = ACT_IDLE;
        endcase
    end

    always_comb
    begin
        done   = (state_reg == ACT_DONE);
        result = result_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ACT_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ACT_IDLE:
            begin
                z_reg    <= z;
                mode_reg <= req.mode;
            end
            ACT_LOOK:
            begin
                a_reg   <= a;
                neg_reg <= x[17];
                t0_reg  <= t0_l;
                d_reg   <= d_l;
                f_reg   <= big ? 7'd0 : a[6:0];
            end
            ACT_MUL, ACT_SQ:
                prod_reg <= prod;
            ACT_CUBE:
            begin
                prod_reg <= prod;
                rem_reg  <= '0;
                quo_reg  <= '0;
                cnt_reg  <= '0;
                den_reg  <= MW'(a_reg);
            end
            ACT_DIV1:
            begin
                if (cnt_reg == DIV1_LAST)
                begin
                    q1_reg  <= quo_n[14:0];
                    rem_reg <= '0;
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    den_reg <= MW'(prod_reg) + {prod_reg[MW-2:0], 1'b0};
                end
                else
                begin
                    rem_reg <= rem_n;
                    quo_reg <= quo_n;
                    cnt_reg <= cnt_reg + 6'd1;
                end
            end
            ACT_DIV2:
            begin
                rem_reg <= rem_n;
                quo_reg <= quo_n;
                cnt_reg <= cnt_reg + 6'd1;
            end
            ACT_FIN:
                result_reg <= sat_dw(v);
            ACT_ATAN:
                result_reg <= sat_dw(rnd_q16(neg_reg ? -t_at : t_at));
            default:
                result_reg <= result_reg;
        endcase
    end

endmodule

// ===== design/dense_layer_forward.sv =====
// Top level of the dense layer: config registers, sequencer and stream ports.
// Per neuron the single multiply-accumulate unit reads one weight per cycle, then the bias,
// and the activation follows (arctan with |z| >= 8 adds a serial divider).
// A run evaluates neuron_count neurons in turn.
// No item is taken while a run is in progress.
// Reset: activation_mode 3, input_count 1, neuron_count 1; stores hold no defined data.
module dense_layer_forward
    import dlf_pkg::*;
#(
    parameter int MAX_NEURONS = 16,
    parameter int MAX_INPUTS  = 64
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [PADDR_W-1:0]     paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_IN_W-1:0]  s_axis_tdata,  // neuron_sel, slot, value
    input  logic [1:0]             s_axis_tuser,  // cmd
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [TDATA_OUT_W-1:0] m_axis_tdata,  // neuron_index, z_value, activation_out
    output logic                   m_axis_tlast
);

    localparam int SLOTS  = MAX_INPUTS + 1;
    localparam int WDEPTH = MAX_NEURONS * SLOTS;
    localparam int WAW    = $clog2(WDEPTH);
    localparam int XW     = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
    localparam int IW     = $clog2(MAX_INPUTS + 1);
    localparam int KW     = (MAX_NEURONS > 1) ? $clog2(MAX_NEURONS) : 1;
    localparam int NW     = $clog2(MAX_NEURONS + 1) + 1;
    localparam int ACC_W  = 2 * DW + IW + 2;

    seq_state_t           state_reg, state_next;
    logic [2:0]           mode_reg;
    logic [6:0]           icount_reg;
    logic [4:0]           ncount_reg;
    logic [IW-1:0]        ni_reg;
    logic [NW-1:0]        nn_reg;
    logic [IW-1:0]        i_reg;
    logic [KW-1:0]        k_reg;
    logic [WAW-1:0]       base_reg;
    logic signed [DW-1:0] z_reg;
    logic                 m_tvalid_reg;
    logic                 m_tlast_reg;
    logic [TDATA_OUT_W-1:0] m_tdata_reg;

    logic                 cfg_we;
    logic                 in_acc;
    cmd_t                 cmd;
    logic [3:0]           sel;
    logic [6:0]           slot;
    logic signed [DW-1:0] value;
    logic                 start_run;
    logic                 last_n;
    logic                 last_i;
    logic                 load;
    logic                 w_we;
    logic                 x_we;
    logic [IW-1:0]        ni_eff;
    logic [NW-1:0]        nn_eff;
    mac_ctrl_t            mac_ctrl;
    act_req_t             act_req;
    logic                 act_done;
    logic signed [DW-1:0] act_res;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] zr;
    logic signed [DW-1:0] zsat;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready;

    always_comb
    begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_MODE:    prdata = 32'(mode_reg);
            REG_INPUTS:  prdata = 32'(icount_reg);
            REG_NEURONS: prdata = 32'(ncount_reg);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDENTITY;
            icount_reg <= 7'd1;
            ncount_reg <= 5'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[3:2])
                REG_MODE:    mode_reg   <= pwdata[2:0];
                REG_INPUTS:  icount_reg <= pwdata[6:0];
                REG_NEURONS: ncount_reg <= pwdata[4:0];
                default:     ;
            endcase
        end
    end

    assign cmd   = cmd_t'(s_axis_tuser);
    assign sel   = s_axis_tdata[3:0];
    assign slot  = s_axis_tdata[10:4];
    assign value = s_axis_tdata[26:11];

    always_comb
    begin
        if (icount_reg == '0)
            ni_eff = IW'(1);
        else if (32'(icount_reg) > MAX_INPUTS)
            ni_eff = IW'(MAX_INPUTS);
        else
            ni_eff = IW'(icount_reg);
        if (ncount_reg == '0)
            nn_eff = NW'(1);
        else if (32'(ncount_reg) > MAX_NEURONS)
            nn_eff = NW'(MAX_NEURONS);
        else
            nn_eff = NW'(ncount_reg);
    end

    assign in_acc    = s_axis_tvalid & s_axis_tready;
    assign start_run = in_acc && ((cmd == CMD_INPUT && s_axis_tlast) || cmd == CMD_RERUN);
    assign w_we      = in_acc && cmd == CMD_WEIGHT && 32'(sel) < MAX_NEURONS
                       && 32'(slot) <= MAX_INPUTS;
    assign x_we      = in_acc && cmd == CMD_INPUT && 32'(slot) < MAX_INPUTS;
    assign last_i    = (i_reg == ni_reg);
    assign last_n    = ((NW'(k_reg) + NW'(1)) == nn_reg);

    assign zr   = (acc + ACC_W'(128)) >>> 8;
    assign zsat = (zr > ACC_W'(32767)) ? 16'sh7fff :
                  (zr < -ACC_W'(32768)) ? 16'sh8000 : zr[DW-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start_run) state_next = ST_MAC;
            ST_MAC:   if (last_i) state_next = ST_DRAIN;
            ST_DRAIN: state_next = ST_START;
            ST_START: state_next = ST_ACT;
            ST_ACT:   if (act_done) state_next = ST_OUT;
            ST_OUT:   if (load) state_next = last_n ? ST_IDLE : ST_MAC;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        s_axis_tready    = (state_reg == ST_IDLE);
        load             = (state_reg == ST_OUT) && (!m_tvalid_reg || m_axis_tready);
        mac_ctrl.rd_en   = (state_reg == ST_MAC);
        mac_ctrl.rd_bias = (state_reg == ST_MAC) && last_i;
        mac_ctrl.clr     = start_run || (load && !last_n);
        act_req.start    = (state_reg == ST_START);
        act_req.mode     = act_mode_t'(mode_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
            ni_reg       <= IW'(1);
            nn_reg       <= NW'(1);
            i_reg        <= '0;
            k_reg        <= '0;
            base_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
                m_tvalid_reg <= 1'b1;
            else if (m_axis_tready)
                m_tvalid_reg <= 1'b0;
            if (start_run)
            begin
                ni_reg   <= ni_eff;
                nn_reg   <= nn_eff;
                i_reg    <= '0;
                k_reg    <= '0;
                base_reg <= '0;
            end
            else if (state_reg == ST_MAC && !last_i)
                i_reg <= i_reg + IW'(1);
            else if (load && !last_n)
            begin
                i_reg    <= '0;
                k_reg    <= k_reg + KW'(1);
                base_reg <= base_reg + WAW'(SLOTS);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_START)
            z_reg <= zsat;
        if (load)
        begin
            m_tdata_reg <= {4'b0, act_res, z_reg, 4'(k_reg)};
            m_tlast_reg <= last_n;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tlast  = m_tlast_reg;

    dlf_mac #(
        .WDEPTH (WDEPTH),
        .WAW    (WAW),
        .XDEPTH (MAX_INPUTS),
        .XW     (XW),
        .ACC_W  (ACC_W)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .w_we    (w_we),
        .w_waddr (WAW'(32'(sel) * SLOTS + 32'(slot))),
        .w_wdata (value),
        .x_we    (x_we),
        .x_waddr (XW'(slot)),
        .x_wdata (value),
        .ctrl    (mac_ctrl),
        .w_raddr (base_reg + WAW'(i_reg)),
        .x_raddr (XW'(i_reg)),
        .acc     (acc)
    );

    dlf_act u_act (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (act_req),
        .z      (zsat),
        .done   (act_done),
        .result (act_res)
    );

`ifndef SYNTHESIS
    a_done_in_act: assert property (@(posedge clk) disable iff (!rst_n)
        act_done |-> state_reg == ST_ACT)
        else $error("activation finished outside its wait state");

    a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (load && last_n) |=> (state_reg == ST_IDLE && m_axis_tlast))
        else $error("run did not close on last neuron");

    a_index_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (i_reg <= ni_reg && NW'(k_reg) < nn_reg))
        else $error("sequencer index out of range");
`endif

endmodule

// ===== bench/tb_top.sv =====
// Testbench for the dense layer: stream stimulus, layer predictor and result checks.
`timescale 1ns / 1ps
module tb_top;
    import dlf_pkg::*;

    localparam int NMAX = 16;
    localparam int IMAX = 64;
    localparam int CYCLE_LIMIT = 3000000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [PADDR_W-1:0] ADDR_BAD = PADDR_W'(12);

    typedef struct {
        logic [3:0]         idx;
        logic signed [15:0] z;
        logic signed [15:0] act;
        logic               last;
    } neuron_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [TDATA_IN_W-1:0] s_axis_tdata = '0;  // neuron_sel, slot, value
    logic [1:0] s_axis_tuser = '0;             // cmd
    logic s_axis_tlast = 1'b0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;      // neuron_index, z_value, activation_out
    logic m_axis_tlast;

    dense_layer_forward dut (.*);

    always #2 clk = ~clk;

    // layer state as seen by the predictor
    logic signed [15:0] weights [NMAX][IMAX+1];
    logic               weight_ok [NMAX][IMAX+1];
    logic signed [15:0] inputs [IMAX];
    logic               input_ok [IMAX];
    logic [2:0] act_mode = MODE_IDENTITY;
    logic [6:0] n_inputs = 7'd1;
    logic [4:0] n_neurons = 5'd1;

    neuron_result_t pending[$];
    int errors = 0;
    int cycles = 0;
    int hold_off = 0;
    bit send_gaps = 1'b0;
    bit recv_gaps = 1'b0;

    const int sig_t[17] = '{32768, 40793, 47911, 53581, 57724, 60565, 62428, 63615, 64357,
                            64816, 65097, 65269, 65374, 65437, 65476, 65500, 65513};
    const int soft_t[17] = '{45426, 31069, 20530, 13200, 8318, 5170, 3184, 1950, 1189,
                             724, 440, 267, 162, 98, 60, 36, 22};
    const int atan_t[17] = '{0, 30386, 51472, 64408, 72558, 78007, 81857, 84705, 86889,
                             88613, 90007, 91157, 92121, 92940, 93644, 94257, 94794};

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int eff_inputs();
        if (n_inputs == 0) return 1;
        return (n_inputs > IMAX) ? IMAX : int'(n_inputs);
    endfunction

    function automatic int eff_neurons();
        if (n_neurons == 0) return 1;
        return (n_neurons > NMAX) ? NMAX : int'(n_neurons);
    endfunction

    function automatic longint table_lookup(int sel, longint unsigned a);
        longint unsigned i, f;
        longint lo, hi;
        if (a >= 2048) i = 16;
        else i = a >> 7;
        f = a & 127;
        lo = (sel == 0) ? sig_t[i] : (sel == 1) ? soft_t[i] : atan_t[i];
        if (i == 16) return lo;
        hi = (sel == 0) ? sig_t[i+1] : (sel == 1) ? soft_t[i+1] : atan_t[i+1];
        return lo + (((hi - lo) * longint'(f)) >>> 7);
    endfunction

    function automatic longint unsigned mag(longint x);
        return (x < 0) ? longint'(-x) : x;
    endfunction

    function automatic longint sigmoid16(longint x);
        longint t;
        t = table_lookup(0, mag(x));
        return (x < 0) ? 65536 - t : t;
    endfunction

    function automatic longint arctan16(longint x);
        longint unsigned a;
        longint t;
        a = mag(x);
        if (a < 2048)
            t = table_lookup(2, a);
        else
        begin
            if (a > 1048576) a = 1048576;
            t = 102944 - longint'(64'd16777216 / a) + longint'((64'd1 << 40) / (3 * a * a * a));
        end
        return (x < 0) ? -t : t;
    endfunction

    function automatic longint round8(longint v);
        return (v + 128) >>> 8;
    endfunction

    function automatic logic signed [15:0] clamp16(longint v);
        if (v > 32767) return 16'sh7fff;
        if (v < -32768) return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic logic signed [15:0] activation_of(longint z);
        longint r;
        case (act_mode)
            MODE_SIGMOID:  r = round8(sigmoid16(z));
            MODE_RELU:     r = (z < 0) ? 0 : z;
            MODE_TANH:     r = round8(2 * sigmoid16(2 * z) - 65536);
            MODE_IDENTITY: r = z;
            MODE_THRESH:   r = (z < 0) ? 0 : 256;
            MODE_LEAKY:    r = (z < 0) ? ((z * 655 + 32768) >>> 16) : z;
            MODE_SOFTPLUS: r = round8(((z > 0) ? z * 256 : 0) + table_lookup(1, mag(z)));
            default:       r = round8(arctan16(z));
        endcase
        return clamp16(r);
    endfunction

    function automatic void predict_layer();
        int ni, nn;
        longint acc;
        neuron_result_t r;
        ni = eff_inputs();
        nn = eff_neurons();
        for (int k = 0; k < nn; k++)
        begin
            acc = longint'(weights[k][ni]) * 256;
            for (int i = 0; i < ni; i++)
                acc += longint'(weights[k][i]) * longint'(inputs[i]);
            r.idx = k[3:0];
            r.z = clamp16((acc + 128) >>> 8);
            r.act = activation_of(longint'(r.z));
            r.last = (k + 1 == nn);
            pending.push_back(r);
        end
    endfunction

    function automatic void apply_item(logic [1:0] cmd, logic [3:0] sel, logic [6:0] slot,
                                       logic signed [15:0] value, logic vend);
        if (cmd == CMD_WEIGHT)
        begin
            if (slot <= IMAX)
            begin
                weights[sel][slot] = value;
                weight_ok[sel][slot] = 1'b1;
            end
        end
        else if (cmd == CMD_INPUT)
        begin
            if (slot < IMAX)
            begin
                inputs[slot] = value;
                input_ok[slot] = 1'b1;
            end
            if (vend) predict_layer();
        end
        else if (cmd == CMD_RERUN)
            predict_layer();
    endfunction

    always @(negedge clk)
    begin
        if (hold_off > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_off <= hold_off - 1;
        end
        else
            m_axis_tready <= recv_gaps ? ($urandom_range(99) >= 24) : 1'b1;
    end

    always @(posedge clk)
    begin
        neuron_result_t e;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending.size() == 0)
            begin
                $error("unexpected result item %h", m_axis_tdata);
                errors++;
            end
            else
            begin
                e = pending.pop_front();
                if (m_axis_tdata[3:0] !== e.idx)
                begin
                    $error("neuron_index expected %0d actual %0d", e.idx, m_axis_tdata[3:0]);
                    errors++;
                end
                if (m_axis_tdata[19:4] !== e.z)
                begin
                    $error("z_value expected %0d actual %0d", e.z,
                           $signed(m_axis_tdata[19:4]));
                    errors++;
                end
                if (m_axis_tdata[35:20] !== e.act)
                begin
                    $error("activation_out expected %0d actual %0d", e.act,
                           $signed(m_axis_tdata[35:20]));
                    errors++;
                end
                if (m_axis_tlast !== e.last)
                begin
                    $error("run_last expected %0d actual %0d", e.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // called and returns at a falling edge
    task automatic send_item(logic [1:0] cmd, logic [3:0] sel, logic [6:0] slot,
                             logic signed [15:0] value, logic vend);
        if (send_gaps && $urandom_range(99) < 24)
            repeat ($urandom_range(1, 4)) @(negedge clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser = cmd;
        s_axis_tlast = vend;
        s_axis_tdata = '0;
        s_axis_tdata[3:0] = sel;
        s_axis_tdata[10:4] = slot;
        s_axis_tdata[26:11] = value;
        do
            @(posedge clk);
        while (!s_axis_tready);
        apply_item(cmd, sel, slot, value, vend);
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic drain();
        while (pending.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_reg(logic [PADDR_W-1:0] addr, logic [31:0] data);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b1; paddr = addr; pwdata = data;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
        case (addr)
            PADDR_W'(REG_MODE * 4):    act_mode = data[2:0];
            PADDR_W'(REG_INPUTS * 4):  n_inputs = data[6:0];
            PADDR_W'(REG_NEURONS * 4): n_neurons = data[4:0];
            default: ;
        endcase
    endtask

    task automatic check_reg(logic [PADDR_W-1:0] addr, logic [31:0] want);
        psel = 1'b1; penable = 1'b0; pwrite = 1'b0; paddr = addr;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        if (prdata !== want)
        begin
            $error("register %0d expected %0d actual %0d", addr, want, prdata);
            errors++;
        end
        @(negedge clk);
        psel = 1'b0; penable = 1'b0;
    endtask

    task automatic configure(logic [2:0] mode, logic [6:0] ni, logic [4:0] nn);
        drain();
        write_reg(PADDR_W'(REG_MODE * 4), {$urandom} & 32'hffff_fff8 | mode);
        write_reg(PADDR_W'(REG_INPUTS * 4), {$urandom} & 32'hffff_ff80 | ni);
        write_reg(PADDR_W'(REG_NEURONS * 4), {$urandom} & 32'hffff_ffe0 | nn);
        check_reg(PADDR_W'(REG_MODE * 4), 32'(mode));
        check_reg(PADDR_W'(REG_INPUTS * 4), 32'(ni));
        check_reg(PADDR_W'(REG_NEURONS * 4), 32'(nn));
    endtask

    function automatic logic signed [15:0] rand_value();
        case ($urandom_range(5))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // every entry an evaluation reads gets written first
    task automatic fill_needed();
        int ni, nn;
        ni = eff_inputs();
        nn = eff_neurons();
        for (int k = 0; k < nn; k++)
            for (int s = 0; s <= ni; s++)
                if (!weight_ok[k][s])
                    send_item(CMD_WEIGHT, k[3:0], s[6:0], rand_value(), 1'b0);
        for (int i = 0; i < ni; i++)
            if (!input_ok[i])
                send_item(CMD_INPUT, 4'($urandom), i[6:0], rand_value(), 1'b0);
    endtask

    task automatic load_vector();
        int ni;
        ni = eff_inputs();
        for (int i = 0; i < ni; i++)
            send_item(CMD_INPUT, 4'($urandom), i[6:0], rand_value(), i == ni - 1);
    endtask

    task automatic rewrite_weights(int count);
        repeat (count)
            send_item(CMD_WEIGHT, 4'($urandom_range(0, eff_neurons() - 1)),
                      7'($urandom_range(0, eff_inputs())), rand_value(), 1'($urandom));
    endtask

    task automatic test_reset_state();
        fill_needed();
        send_item(CMD_RERUN, 4'd0, 7'd0, 16'sd0, 1'b0);
        drain();
    endtask

    task automatic test_directed();
        configure(MODE_IDENTITY, 7'd4, 5'd3);
        for (int k = 0; k < 3; k++)
            for (int s = 0; s <= 4; s++)
                send_item(CMD_WEIGHT, k[3:0], s[6:0], (k == 0) ? 16'sh7fff :
                          (k == 1) ? 16'sh8000 : 16'sd64, 1'b0);
        send_item(CMD_WEIGHT, 4'd15, 7'd127, 16'sh7fff, 1'b0);
        send_item(CMD_WEIGHT, 4'd2, 7'd65, 16'sh8000, 1'b1);
        send_item(CMD_UNUSED, 4'd15, 7'd127, 16'sh7fff, 1'b1);
        send_item(CMD_INPUT, 4'd0, 7'd0, 16'sh7fff, 1'b0);
        send_item(CMD_INPUT, 4'd0, 7'd1, 16'sh8000, 1'b0);
        send_item(CMD_INPUT, 4'd0, 7'd2, 16'sd256, 1'b0);
        send_item(CMD_INPUT, 4'd0, 7'd3, -16'sd256, 1'b1);
        send_item(CMD_INPUT, 4'd0, 7'd100, 16'sd3, 1'b1);
        for (int m = 0; m < 8; m++)
        begin
            configure(m[2:0], 7'd4, 5'd3);
            send_item(CMD_RERUN, 4'd0, 7'd0, 16'sd0, 1'b0);
        end
        drain();
        write_reg(ADDR_BAD, 32'hffff_ffff);
    endtask

    task automatic test_random(int phases);
        logic [6:0] ni;
        logic [4:0] nn;
        for (int p = 0; p < phases; p++)
        begin
            case ($urandom_range(9))
                0: begin ni = 7'($urandom_range(65, 127)); nn = 5'($urandom_range(1, 2)); end
                1: begin ni = 7'($urandom_range(0, 3)); nn = 5'($urandom_range(16, 31)); end
                2: begin ni = 7'd0; nn = 5'd0; end
                default: begin ni = 7'($urandom_range(1, 8)); nn = 5'($urandom_range(1, 4)); end
            endcase
            configure(3'($urandom), ni, nn);
            fill_needed();
            repeat ($urandom_range(2, 4))
            begin
                case ($urandom_range(9))
                    0: send_item(CMD_UNUSED, 4'($urandom), 7'($urandom), 16'($urandom),
                                 1'($urandom));
                    1: send_item(CMD_WEIGHT, 4'($urandom), 7'($urandom_range(65, 127)),
                                 16'($urandom), 1'($urandom));
                    2: send_item(CMD_INPUT, 4'($urandom), 7'($urandom_range(64, 127)),
                                 16'($urandom), 1'b1);
                    3, 4: send_item(CMD_RERUN, 4'($urandom), 7'($urandom), 16'($urandom),
                                    1'($urandom));
                    default:
                    begin
                        rewrite_weights($urandom_range(0, 3));
                        load_vector();
                    end
                endcase
            end
        end
        drain();
    endtask

    task automatic test_backpressure();
        configure(MODE_SIGMOID, 7'd2, 5'd16);
        fill_needed();
        hold_off = 400;
        repeat (4) send_item(CMD_RERUN, 4'd0, 7'd0, 16'sd0, 1'b0);
        load_vector();
        drain();
    endtask

    initial
    begin
        for (int k = 0; k < NMAX; k++)
            for (int s = 0; s <= IMAX; s++)
                weight_ok[k][s] = 1'b0;
        for (int i = 0; i < IMAX; i++)
            input_ok[i] = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);
        test_reset_state();
        test_directed();
        test_random(3);
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        test_random(3);
        test_backpressure();
        test_random(2);
        drain();
        repeat (3000) @(posedge clk);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
